### sv/gpct_pkg.sv
// grace period checkpoint tracker: shared types, codes and constants
// used by the channel interfaces, the top level and the checker; no dependencies

package gpct_pkg;

  localparam int NCPU_DEFAULT       = 8;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int OP_W     = 2;
  localparam int CPU_W    = 3;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int REL_W    = 16;
  localparam int ID_W     = 32;
  localparam int THRESH_W = 16;

  localparam logic [ID_W-1:0]     INITIAL_GLOBAL_ID = 32'hFFFF_FFF6;
  localparam logic [THRESH_W-1:0] WARN_RESET        = 16'd10000;
  localparam logic [REL_W-1:0]    REL_MAX           = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_TICK       = 2'd2,
    OP_DEFER      = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 2'd0,
    KIND_COMMITTED = 2'd1,
    KIND_PERIODIC  = 2'd2,
    KIND_FAILED    = 2'd3
  } kind_t;

  typedef struct packed {
    status_t          status;
    kind_t            checkin_kind;
    logic             global_checkpoint;
    logic [REL_W-1:0] released_works;
    logic [ID_W-1:0]  checkpoint_id;
    logic             warning;
  } result_t;

endpackage

### sv/gpct_in_if.sv
// event request channel of the checkpoint tracker: valid, ready and event fields
// depends on gpct_pkg

interface gpct_in_if;
  import gpct_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [CPU_W-1:0] cpu_index;
  logic             in_read_cs;

  modport source (output valid, opcode, cpu_index, in_read_cs, input ready);
  modport sink   (input valid, opcode, cpu_index, in_read_cs, output ready);
endinterface

### sv/gpct_out_if.sv
// result channel of the checkpoint tracker: valid, ready and result fields
// depends on gpct_pkg

interface gpct_out_if;
  import gpct_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   checkin_kind;
  logic                global_checkpoint;
  logic [REL_W-1:0]    released_works;
  logic [ID_W-1:0]     checkpoint_id;
  logic                warning;

  modport source (output valid, status, checkin_kind, global_checkpoint, released_works,
                  checkpoint_id, warning, input ready);
  modport sink   (input valid, status, checkin_kind, global_checkpoint, released_works,
                  checkpoint_id, warning, output ready);
endinterface

### sv/gpct_cfg_if.sv
// configuration write channel of the checkpoint tracker: warn threshold data
// depends on gpct_pkg

interface gpct_cfg_if;
  import gpct_pkg::*;

  logic                valid;
  logic                ready;
  logic [THRESH_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/grace_period_checkpoint_tracker.sv
// grace period checkpoint tracker: register, unregister, tick and defer events
// result shown the cycle after its request is accepted; throughput 1 request per
// cycle while results are taken, set by the single pass of mask and counter logic
// ahead of the result register; ready stays high while it is empty or being taken
// synchronous reset clears masks, counts and warning, loads the initial global id
// depends on gpct_pkg, gpct_in_if, gpct_out_if, gpct_cfg_if

module grace_period_checkpoint_tracker #(
  parameter int NCPU       = gpct_pkg::NCPU_DEFAULT,
  parameter int COUNT_BITS = gpct_pkg::COUNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  gpct_in_if.sink    in_ch,
  gpct_out_if.source out_ch,
  gpct_cfg_if.sink   cfg
);
  import gpct_pkg::*;

  localparam int RC_W = $clog2(NCPU + 1);
  localparam int TW   = (COUNT_BITS + 1 > THRESH_W) ? COUNT_BITS + 1 : THRESH_W;
  localparam int RW   = (COUNT_BITS > REL_W) ? COUNT_BITS : REL_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [THRESH_W-1:0]   warn_threshold;
  logic [NCPU-1:0]       registered_mask, registered_mask_next;
  logic [NCPU-1:0]       pending_mask, pending_mask_next;
  logic [RC_W-1:0]       registered_count, registered_count_next;
  logic [RC_W-1:0]       pending_count, pending_count_next;
  logic [ID_W-1:0]       global_id, global_id_next;
  logic [ID_W-1:0]       local_id [NCPU];
  logic [ID_W-1:0]       local_id_next [NCPU];
  logic [COUNT_BITS-1:0] cpu_pending_count [NCPU];
  logic [COUNT_BITS-1:0] cpu_pending_count_next [NCPU];
  logic [COUNT_BITS-1:0] current_gen_count, current_gen_count_next;
  logic [COUNT_BITS-1:0] older_gen_count, older_gen_count_next;
  logic                  warned, warned_next;

  result_t res, res_next;
  logic    out_valid;
  logic    accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;

  always_comb begin
    logic [NCPU-1:0]       sel;
    logic                  legal, is_reg, pend_hit, do_flush, do_commit, do_ckpt, sat;
    logic [ID_W-1:0]       lid;
    logic [COUNT_BITS-1:0] cpc;
    logic [COUNT_BITS:0]   sum;
    logic [TW-1:0]         total;
    logic [RW-1:0]         rel;
    logic [COUNT_BITS-1:0] rel_cnt;

    registered_mask_next   = registered_mask;
    pending_mask_next      = pending_mask;
    registered_count_next  = registered_count;
    pending_count_next     = pending_count;
    global_id_next         = global_id;
    local_id_next          = local_id;
    cpu_pending_count_next = cpu_pending_count;
    current_gen_count_next = current_gen_count;
    older_gen_count_next   = older_gen_count;
    warned_next            = warned;

    res_next.status            = ST_OK;
    res_next.checkin_kind      = KIND_NONE;
    res_next.global_checkpoint = 1'b0;
    res_next.warning           = 1'b0;

    do_flush  = 1'b0;
    do_commit = 1'b0;
    do_ckpt   = 1'b0;
    sat       = 1'b0;
    sum       = '0;
    total     = '0;
    rel_cnt   = '0;

    // one-hot processor select and its state
    legal = int'(in_ch.cpu_index) < NCPU;
    lid   = '0;
    cpc   = '0;
    for (int i = 0; i < NCPU; i++) begin
      sel[i] = (int'(in_ch.cpu_index) == i);
      if (sel[i]) begin
        lid = lid | local_id[i];
        cpc = cpc | cpu_pending_count[i];
      end
    end
    is_reg   = |(registered_mask & sel);
    pend_hit = |(pending_mask & sel);

    if (!legal) begin
      res_next.status = ST_ILLEGAL;
    end else begin
      unique case (opcode_t'(in_ch.opcode))
        OP_REGISTER: begin
          if (is_reg) begin
            res_next.status = ST_ILLEGAL;
          end else begin
            for (int i = 0; i < NCPU; i++) begin
              if (sel[i]) begin
                local_id_next[i] = global_id;
              end
            end
            registered_mask_next  = registered_mask | sel;
            registered_count_next = registered_count + RC_W'(1);
            if (registered_count_next == RC_W'(1) && pending_count == '0) begin
              do_ckpt = 1'b1;
            end
          end
        end
        OP_UNREGISTER: begin
          if (!is_reg) begin
            res_next.status = ST_ILLEGAL;
          end else begin
            do_flush              = 1'b1;
            do_commit             = 1'b1;
            registered_mask_next  = registered_mask & ~sel;
            registered_count_next = registered_count - RC_W'(1);
          end
        end
        OP_TICK: begin
          if (is_reg) begin
            do_flush = 1'b1;
            if (lid == global_id) begin
              res_next.checkin_kind = KIND_COMMITTED;
              do_commit             = 1'b1;
            end else if (in_ch.in_read_cs) begin
              res_next.checkin_kind = KIND_FAILED;
            end else begin
              for (int i = 0; i < NCPU; i++) begin
                if (sel[i]) begin
                  local_id_next[i] = global_id;
                end
              end
              res_next.checkin_kind = KIND_PERIODIC;
              do_commit             = 1'b1;
            end
          end
        end
        OP_DEFER: begin
          if (!is_reg) begin
            res_next.status = ST_ILLEGAL;
          end else begin
            sum = {1'b0, cpc} + (COUNT_BITS + 1)'(1);
            sat = sum[COUNT_BITS];
            for (int i = 0; i < NCPU; i++) begin
              if (sel[i]) begin
                cpu_pending_count_next[i] = sat ? COUNT_MAX : sum[COUNT_BITS-1:0];
              end
            end
          end
        end
      endcase
    end

    // move the processor's deferred works into the current generation
    if (do_flush) begin
      sum = {1'b0, current_gen_count} + {1'b0, cpc};
      if (sum[COUNT_BITS]) begin
        sat = 1'b1;
      end
      current_gen_count_next = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
      for (int i = 0; i < NCPU; i++) begin
        if (sel[i]) begin
          cpu_pending_count_next[i] = '0;
        end
      end
    end

    if (do_commit && pend_hit) begin
      pending_mask_next  = pending_mask & ~sel;
      pending_count_next = pending_count - RC_W'(1);
      if (pending_count_next == '0) begin
        do_ckpt = 1'b1;
      end
    end

    if (do_ckpt) begin
      total = TW'(current_gen_count_next) + TW'(older_gen_count);
      if (!warned && total >= TW'(warn_threshold)) begin
        warned_next      = 1'b1;
        res_next.warning = 1'b1;
      end
      if (registered_count_next == '0) begin
        sum = {1'b0, older_gen_count} + {1'b0, current_gen_count_next};
        if (sum[COUNT_BITS]) begin
          sat = 1'b1;
        end
        rel_cnt              = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        older_gen_count_next = '0;
      end else begin
        pending_mask_next    = registered_mask_next;
        pending_count_next   = registered_count_next;
        rel_cnt              = older_gen_count;
        older_gen_count_next = current_gen_count_next;
      end
      current_gen_count_next     = '0;
      global_id_next             = global_id + ID_W'(1);
      res_next.global_checkpoint = 1'b1;
    end

    rel = RW'(rel_cnt);
    res_next.released_works = (rel > RW'(REL_MAX)) ? REL_MAX : rel[REL_W-1:0];
    res_next.checkpoint_id  = global_id_next;

    if (res_next.status == ST_OK && sat) begin
      res_next.status = ST_SATURATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_threshold    <= WARN_RESET;
      registered_mask   <= '0;
      pending_mask      <= '0;
      registered_count  <= '0;
      pending_count     <= '0;
      global_id         <= INITIAL_GLOBAL_ID;
      current_gen_count <= '0;
      older_gen_count   <= '0;
      warned            <= 1'b0;
      out_valid         <= 1'b0;
      for (int i = 0; i < NCPU; i++) begin
        local_id[i]          <= '0;
        cpu_pending_count[i] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        warn_threshold <= cfg.data;
      end
      if (accept) begin
        registered_mask   <= registered_mask_next;
        pending_mask      <= pending_mask_next;
        registered_count  <= registered_count_next;
        pending_count     <= pending_count_next;
        global_id         <= global_id_next;
        local_id          <= local_id_next;
        cpu_pending_count <= cpu_pending_count_next;
        current_gen_count <= current_gen_count_next;
        older_gen_count   <= older_gen_count_next;
        warned            <= warned_next;
        out_valid         <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.status            = res.status;
  assign out_ch.checkin_kind      = res.checkin_kind;
  assign out_ch.global_checkpoint = res.global_checkpoint;
  assign out_ch.released_works    = res.released_works;
  assign out_ch.checkpoint_id     = res.checkpoint_id;
  assign out_ch.warning           = res.warning;

endmodule

### sv/gpct_checker.sv
// port-level checks of the checkpoint tracker, bound to the top level
// depends on gpct_pkg and grace_period_checkpoint_tracker

module gpct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gpct_pkg::STATUS_W-1:0] status,
  input logic [gpct_pkg::KIND_W-1:0]   checkin_kind,
  input logic                          global_checkpoint,
  input logic [gpct_pkg::REL_W-1:0]    released_works,
  input logic [gpct_pkg::ID_W-1:0]     checkpoint_id,
  input logic                          warning
);
  import gpct_pkg::*;

  // an accepted request shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accepted request");

  // an illegal request reports no checkin, checkpoint, release or warning
  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ILLEGAL |->
      checkin_kind == KIND_NONE && !global_checkpoint && released_works == '0 && !warning)
    else $error("illegal request reported side effects");

  // releases and the warning only come with a global checkpoint
  a_release_ckpt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (released_works != '0 || warning) |-> global_checkpoint)
    else $error("release or warning without checkpoint");

  // a failed checkin never completes a grace period
  a_failed_no_ckpt: assert property (@(posedge clk) disable iff (rst)
    out_valid && checkin_kind == KIND_FAILED |-> !global_checkpoint)
    else $error("failed checkin advanced the checkpoint");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checkpoint_id) && $stable(status))
    else $error("stalled result changed");

endmodule

bind grace_period_checkpoint_tracker gpct_checker u_gpct_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .status            (out_ch.status),
  .checkin_kind      (out_ch.checkin_kind),
  .global_checkpoint (out_ch.global_checkpoint),
  .released_works    (out_ch.released_works),
  .checkpoint_id     (out_ch.checkpoint_id),
  .warning           (out_ch.warning)
);
